[src/hsv2rgb_pkg.sv]
// ----------------------------------------------------------------------------
// HSV to RGB package
// Shared types, constants and the hue sextant decoder for the converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

	// Hue sextants, in the order of the color wheel
	typedef enum logic [2:0] {
		SEXT_RED_YEL,
		SEXT_YEL_GRN,
		SEXT_GRN_CYN,
		SEXT_CYN_BLU,
		SEXT_BLU_MAG,
		SEXT_MAG_RED
	} sext_t;

	// Load enables of the pipeline stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

	// Decoded hue: sextant and triangle weight t (0..60)
	typedef struct packed {
		sext_t      sext;
		logic [5:0] t;
	} hue_split_t;

	localparam int HUE_SEG    = 60;
	localparam int NUM_W      = 22;     // channel numerator width
	localparam int DIV_DEN    = 15300;  // 255 * 60
	localparam int DIV_SHIFT  = 28;
	localparam int DIV_RECIP  = 17544;  // floor(2^28 / 15300)
	localparam int RECIP_W    = 15;
	localparam int CHAN_MAX   = 255;

	// Split hue into sextant and weight of the secondary component
	function automatic hue_split_t hue_split(input logic [8:0] h);
		logic [3:0] seg;
		logic [8:0] rem9;
		logic [5:0] rem;
		logic [3:0] sx;
		hue_split_t res;
		seg = 4'd0;
		for (int i = 1; i <= 8; i++) begin
			if (h >= 9'(i * HUE_SEG)) begin
				seg = 4'(i);
			end
		end
		rem9 = h - 9'(9'(seg) * 9'(HUE_SEG));
		rem  = rem9[5:0];
		sx   = (seg >= 4'd6) ? seg - 4'd6 : seg;
		res.sext = sext_t'(sx[2:0]);
		res.t    = seg[0] ? 6'(HUE_SEG) - rem : rem;
		return res;
	endfunction

endpackage

[src/hsv2rgb_ifs.sv]
// ----------------------------------------------------------------------------
// HSV to RGB stream interfaces
// Valid/ready channels for HSV input pixels and RGB output pixels.
// ----------------------------------------------------------------------------
interface hsv2rgb_hsv_if;
	logic       valid;
	logic       ready;
	logic [8:0] hue_degrees;
	logic [7:0] saturation;
	logic [7:0] brightness;

	modport source(output valid, output hue_degrees, output saturation,
		output brightness, input ready);
	modport sink(input valid, input hue_degrees, input saturation,
		input brightness, output ready);
endinterface

interface hsv2rgb_rgb_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source(output valid, output red, output green, output blue,
		input ready);
	modport sink(input valid, input red, input green, input blue,
		output ready);
endinterface

[src/hsv_to_rgb_converter.sv]
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Four-stage pipeline turning whole-degree HSV pixels into 8-bit RGB.
// ----------------------------------------------------------------------------
// Usage:
//   hsv  : sink channel, one HSV pixel per transfer (hue 0..359 degrees,
//          saturation and brightness as 8-bit fractions of 255).
//   rgb  : source channel, one RGB pixel per transfer, channels truncated.
//   Every input transfer yields exactly one output transfer, in order.
//   Each pixel passes through the stage 1 to stage 4 registers in order
//   before it is offered on rgb.
//   Throughput: one pixel per clock while rgb.ready is high; the path is set by four register
//   stages (hue decode and 8x8 products, channel numerators, reciprocal
//   multiply, remainder fixup).
//   Stall: each stage holds while its successor is full and stalled; empty
//   stages keep filling, so up to four pixels are buffered and hsv.ready
//   falls only when all stages are full and rgb.ready is low.
//   Reset: arst_n clears all stage valid bits; the pipeline comes up empty
//   and ready.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
	input  logic          clk,
	input  logic          arst_n,
	hsv2rgb_hsv_if.sink   hsv,
	hsv2rgb_rgb_if.source rgb
);

	hsv2rgb_pkg::stage_en_t en;
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	logic [hsv2rgb_pkg::NUM_W-1:0] num_x_s2;
	logic [hsv2rgb_pkg::NUM_W-1:0] num_0_s2;
	hsv2rgb_pkg::sext_t            sext_s2, sext_s3, sext_s4;
	logic [7:0]                    v_s2, v_s3, v_s4;
	logic [7:0]                    qx_s4, q0_s4;

	// Advance a stage when it is empty or its successor takes its item
	assign rdy_s4 = !valid_s4 || rgb.ready;
	assign rdy_s3 = !valid_s3 || rdy_s4;
	assign rdy_s2 = !valid_s2 || rdy_s3;
	assign rdy_s1 = !valid_s1 || rdy_s2;

	assign en.s1 = rdy_s1;
	assign en.s2 = rdy_s2;
	assign en.s3 = rdy_s3;
	assign en.s4 = rdy_s4;

	assign hsv.ready = rdy_s1;
	assign rgb.valid = valid_s4;

	// Track stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= hsv.valid;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
			if (rdy_s4) valid_s4 <= valid_s3;
		end
	end

	hsv2rgb_front u_front (
		.clk         (clk),
		.en          (en),
		.hue_degrees (hsv.hue_degrees),
		.saturation  (hsv.saturation),
		.brightness  (hsv.brightness),
		.num_x_s2    (num_x_s2),
		.num_0_s2    (num_0_s2),
		.sext_s2     (sext_s2),
		.v_s2        (v_s2)
	);

	hsv2rgb_cdiv u_div_x (
		.clk     (clk),
		.en      (en),
		.num     (num_x_s2),
		.quot_s4 (qx_s4)
	);

	hsv2rgb_cdiv u_div_0 (
		.clk     (clk),
		.en      (en),
		.num     (num_0_s2),
		.quot_s4 (q0_s4)
	);

	// Carry sextant and brightness alongside the dividers
	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			sext_s3 <= sext_s2;
			v_s3    <= v_s2;
		end
		if (rdy_s4) begin
			sext_s4 <= sext_s3;
			v_s4    <= v_s3;
		end
	end

	// Route chroma, secondary and zero channels by sextant
	always_comb begin
		case (sext_s4)
			hsv2rgb_pkg::SEXT_RED_YEL: begin
				rgb.red = v_s4;  rgb.green = qx_s4; rgb.blue = q0_s4;
			end
			hsv2rgb_pkg::SEXT_YEL_GRN: begin
				rgb.red = qx_s4; rgb.green = v_s4;  rgb.blue = q0_s4;
			end
			hsv2rgb_pkg::SEXT_GRN_CYN: begin
				rgb.red = q0_s4; rgb.green = v_s4;  rgb.blue = qx_s4;
			end
			hsv2rgb_pkg::SEXT_CYN_BLU: begin
				rgb.red = q0_s4; rgb.green = qx_s4; rgb.blue = v_s4;
			end
			hsv2rgb_pkg::SEXT_BLU_MAG: begin
				rgb.red = qx_s4; rgb.green = q0_s4; rgb.blue = v_s4;
			end
			hsv2rgb_pkg::SEXT_MAG_RED: begin
				rgb.red = v_s4;  rgb.green = q0_s4; rgb.blue = qx_s4;
			end
			default: begin
				rgb.red = v_s4;  rgb.green = v_s4;  rgb.blue = v_s4;
			end
		endcase
	end

`ifndef ASSERT_OFF
	// An input transfer always lands in stage 1
	a_enter_s1: assert property (@(posedge clk) disable iff (!arst_n)
		hsv.valid && hsv.ready |=> valid_s1)
		else $error("accepted pixel missing from stage 1");

	// With the output stage empty the whole pipeline must accept
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s4 |-> hsv.ready)
		else $error("input stalled with empty output stage");

	// In the red-yellow sextant red >= green >= blue
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && sext_s4 == hsv2rgb_pkg::SEXT_RED_YEL |->
			rgb.red >= rgb.green && rgb.green >= rgb.blue)
		else $error("channel order broken in red-yellow sextant");
`endif

endmodule

[src/hsv2rgb_front.sv]
// ----------------------------------------------------------------------------
// HSV to RGB front end
// Stages 1 and 2: hue decode, chroma products and channel numerators.
// ----------------------------------------------------------------------------
module hsv2rgb_front (
	input  logic                          clk,
	input  hsv2rgb_pkg::stage_en_t        en,
	input  logic [8:0]                    hue_degrees,
	input  logic [7:0]                    saturation,
	input  logic [7:0]                    brightness,
	output logic [hsv2rgb_pkg::NUM_W-1:0] num_x_s2,
	output logic [hsv2rgb_pkg::NUM_W-1:0] num_0_s2,
	output hsv2rgb_pkg::sext_t            sext_s2,
	output logic [7:0]                    v_s2
);

	hsv2rgb_pkg::hue_split_t split;
	logic [15:0]             vs_s1;
	logic [15:0]             vns_s1;
	logic [5:0]              t_s1;
	hsv2rgb_pkg::sext_t      sext_s1;
	logic [7:0]              v_s1;
	logic [hsv2rgb_pkg::NUM_W-1:0] m_num;
	logic [hsv2rgb_pkg::NUM_W-1:0] x_num;

	assign split = hsv2rgb_pkg::hue_split(hue_degrees);

	// Stage 1: v*s, v*(255-s) and the decoded hue
	always_ff @(posedge clk) begin
		if (en.s1) begin
			vs_s1   <= 16'(brightness) * 16'(saturation);
			vns_s1  <= 16'(brightness) * 16'(8'hff - saturation);
			t_s1    <= split.t;
			sext_s1 <= split.sext;
			v_s1    <= brightness;
		end
	end

	// Stage 2: numerators of the secondary and the zero channels
	assign m_num = hsv2rgb_pkg::NUM_W'(vns_s1) * hsv2rgb_pkg::NUM_W'(hsv2rgb_pkg::HUE_SEG);
	assign x_num = hsv2rgb_pkg::NUM_W'(vs_s1) * hsv2rgb_pkg::NUM_W'(t_s1);

	always_ff @(posedge clk) begin
		if (en.s2) begin
			num_x_s2 <= x_num + m_num;
			num_0_s2 <= m_num;
			sext_s2  <= sext_s1;
			v_s2     <= v_s1;
		end
	end

endmodule

[src/hsv2rgb_cdiv.sv]
// ----------------------------------------------------------------------------
// HSV to RGB constant divider
// Stages 3 and 4: floor(num / 15300) by reciprocal multiply and one fixup.
// ----------------------------------------------------------------------------
module hsv2rgb_cdiv (
	input  logic                          clk,
	input  hsv2rgb_pkg::stage_en_t        en,
	input  logic [hsv2rgb_pkg::NUM_W-1:0] num,
	output logic [7:0]                    quot_s4
);

	localparam int PROD_W = hsv2rgb_pkg::NUM_W + hsv2rgb_pkg::RECIP_W;

	logic [PROD_W-1:0]               prod;
	logic [8:0]                      q0_s3;
	logic [hsv2rgb_pkg::NUM_W-1:0]   num_s3;
	logic [hsv2rgb_pkg::NUM_W:0]     base;
	logic [hsv2rgb_pkg::NUM_W:0]     rem;
	logic [8:0]                      qc;

	// Stage 3: estimate, low by at most one
	assign prod = PROD_W'(num) * PROD_W'(hsv2rgb_pkg::DIV_RECIP);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			q0_s3  <= prod[hsv2rgb_pkg::DIV_SHIFT+8:hsv2rgb_pkg::DIV_SHIFT];
			num_s3 <= num;
		end
	end

	// Stage 4: correct the estimate from the remainder, clamp to 8 bits
	always_comb begin
		base = (hsv2rgb_pkg::NUM_W+1)'(q0_s3) * (hsv2rgb_pkg::NUM_W+1)'(hsv2rgb_pkg::DIV_DEN);
		rem  = (hsv2rgb_pkg::NUM_W+1)'(num_s3) - base;
		qc   = (rem >= (hsv2rgb_pkg::NUM_W+1)'(hsv2rgb_pkg::DIV_DEN)) ? q0_s3 + 9'd1 : q0_s3;
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			quot_s4 <= (qc > 9'(hsv2rgb_pkg::CHAN_MAX)) ? 8'hff : qc[7:0];
		end
	end

endmodule

[verif/hsv_to_rgb_converter_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Drives HSV pixels through the valid/ready input channel, predicts each RGB
// pixel from a typed row or an integer model of the conversion and checks the output
// stream in order, under random idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_test;

	localparam int HALF_PERIOD  = 5;
	localparam int RESET_CYCLES = 6;
	localparam int LONG_HOLD    = 60;
	localparam int STALL_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RAND_CHUNKS  = 15;
	localparam int CHUNK_ITEMS  = 102;
	localparam int HOLD_CHUNK   = 5;
	localparam int MAX_REPORTS  = 10;
	localparam int NUM_DIRECTED = 22;

	// Idling modes of either side
	localparam int IDLE_NONE = 0;
	localparam int IDLE_SOME = 1;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_pixel_t;

	// Directed row: input pixel, whether a hand-written result applies, and that result
	typedef struct packed {
		logic [8:0] hue;
		logic [7:0] sat;
		logic [7:0] bri;
		logic       typed;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} hsv_row_t;

	localparam hsv_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
		'{9'd0,   8'd0,   8'd0,   1'b1, 8'd0,   8'd0,   8'd0},   // black
		'{9'd0,   8'd0,   8'd255, 1'b1, 8'd255, 8'd255, 8'd255}, // white
		'{9'd200, 8'd0,   8'd128, 1'b1, 8'd128, 8'd128, 8'd128}, // gray, no chroma
		'{9'd0,   8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0},   // red
		'{9'd60,  8'd255, 8'd255, 1'b1, 8'd255, 8'd255, 8'd0},   // yellow
		'{9'd120, 8'd255, 8'd255, 1'b1, 8'd0,   8'd255, 8'd0},   // green
		'{9'd180, 8'd255, 8'd255, 1'b1, 8'd0,   8'd255, 8'd255}, // cyan
		'{9'd240, 8'd255, 8'd255, 1'b1, 8'd0,   8'd0,   8'd255}, // blue
		'{9'd300, 8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd255}, // magenta
		'{9'd359, 8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
		'{9'd59,  8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
		'{9'd61,  8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
		'{9'd360, 8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0},   // wraps to red
		'{9'd420, 8'd255, 8'd255, 1'b1, 8'd255, 8'd255, 8'd0},   // wraps to yellow
		'{9'd480, 8'd255, 8'd255, 1'b1, 8'd0,   8'd255, 8'd0},   // wraps to green
		'{9'd511, 8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
		'{9'd256, 8'd170, 8'd85,  1'b0, 8'd0,   8'd0,   8'd0},
		'{9'd90,  8'd128, 8'd200, 1'b0, 8'd0,   8'd0,   8'd0},
		'{9'd0,   8'd255, 8'd0,   1'b1, 8'd0,   8'd0,   8'd0},   // zero brightness
		'{9'd300, 8'd1,   8'd1,   1'b0, 8'd0,   8'd0,   8'd0},
		'{9'd150, 8'd254, 8'd254, 1'b0, 8'd0,   8'd0,   8'd0},
		'{9'd30,  8'd85,  8'd170, 1'b0, 8'd0,   8'd0,   8'd0}
	};

	logic clk;
	logic arst_n;

	hsv2rgb_hsv_if hsv_ch();
	hsv2rgb_rgb_if rgb_ch();

	hsv_to_rgb_converter DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.hsv   (hsv_ch),
		.rgb   (rgb_ch)
	);

	rgb_pixel_t  rgb_expected [$];
	int unsigned error_count;
	int unsigned pixels_out;
	int unsigned stall_cycles;
	int          src_mode;
	int          sink_mode;
	logic        hold_req;
	logic        hold_done;
	int unsigned hold_count;
	int unsigned sink_wait;

	// Clock
	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// Truncate a channel numerator (units of 1/15300) to 8 bits
	function automatic logic [7:0] channel_of(input int unsigned num);
		int unsigned q;
		q = num / hsv2rgb_pkg::DIV_DEN;
		return (q > hsv2rgb_pkg::CHAN_MAX) ? 8'(hsv2rgb_pkg::CHAN_MAX) : 8'(q);
	endfunction

	// Exact integer HSV to RGB conversion
	function automatic rgb_pixel_t hsv_pixel_to_rgb(input logic [8:0] hue,
		input logic [7:0] sat, input logic [7:0] bri);
		int unsigned h, s, v, wedge, tri_w, chroma, second, offset;
		int unsigned num_r, num_g, num_b;
		hsv2rgb_pkg::sext_t sext;
		rgb_pixel_t px;
		h = hue;
		s = sat;
		v = bri;
		// weight of the secondary component peaks mid-sextant pair
		wedge  = h % (2 * hsv2rgb_pkg::HUE_SEG);
		tri_w  = (wedge >= hsv2rgb_pkg::HUE_SEG) ? 2 * hsv2rgb_pkg::HUE_SEG - wedge : wedge;
		chroma = v * s * hsv2rgb_pkg::HUE_SEG;
		second = v * s * tri_w;
		offset = v * (hsv2rgb_pkg::CHAN_MAX - s) * hsv2rgb_pkg::HUE_SEG;
		sext   = hsv2rgb_pkg::sext_t'((h % (6 * hsv2rgb_pkg::HUE_SEG)) / hsv2rgb_pkg::HUE_SEG);
		case (sext)
			hsv2rgb_pkg::SEXT_RED_YEL: begin
				num_r = chroma; num_g = second; num_b = 0;
			end
			hsv2rgb_pkg::SEXT_YEL_GRN: begin
				num_r = second; num_g = chroma; num_b = 0;
			end
			hsv2rgb_pkg::SEXT_GRN_CYN: begin
				num_r = 0; num_g = chroma; num_b = second;
			end
			hsv2rgb_pkg::SEXT_CYN_BLU: begin
				num_r = 0; num_g = second; num_b = chroma;
			end
			hsv2rgb_pkg::SEXT_BLU_MAG: begin
				num_r = second; num_g = 0; num_b = chroma;
			end
			default: begin
				num_r = chroma; num_g = 0; num_b = second;
			end
		endcase
		px.red   = channel_of(num_r + offset);
		px.green = channel_of(num_g + offset);
		px.blue  = channel_of(num_b + offset);
		return px;
	endfunction

	// Mostly short gaps, a few long ones
	function automatic int unsigned pick_gap(input int mode);
		int unsigned r;
		if (mode == IDLE_NONE) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(4, 24);
	endfunction

	// Saturation or brightness, weighted toward the extremes
	function automatic logic [7:0] pick_fraction();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			return 8'd0;
		end else if (r < 30) begin
			return 8'd255;
		end else if (r < 35) begin
			return ($urandom_range(0, 1) != 0) ? 8'd1 : 8'd254;
		end
		return 8'($urandom_range(0, 255));
	endfunction

	// Hue: mostly in range, some near sextant borders, some above 359
	function automatic logic [8:0] pick_hue();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return 9'($urandom_range(0, 359));
		end else if (r < 85) begin
			return 9'($urandom_range(0, 8) * hsv2rgb_pkg::HUE_SEG
				+ $urandom_range(0, 2) - 1);
		end
		return 9'($urandom_range(0, 511));
	endfunction

	// Offer one pixel at a falling edge, hold it until the transfer, then record the result
	task automatic send_pixel(input logic [8:0] hue, input logic [7:0] sat,
		input logic [7:0] bri, input rgb_pixel_t want, input int unsigned gap);
		if (gap > 0) begin
			hsv_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		hsv_ch.valid       <= 1'b1;
		hsv_ch.hue_degrees <= hue;
		hsv_ch.saturation  <= sat;
		hsv_ch.brightness  <= bri;
		do begin
			@(posedge clk);
		end while (!hsv_ch.ready);
		rgb_expected = {rgb_expected, want};
		@(negedge clk);
	endtask

	// Output side: random ready gaps, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_req && !hold_done) begin
			if (hold_count == LONG_HOLD) begin
				hold_done = 1'b1;
				rgb_ch.ready <= 1'b1;
			end else begin
				hold_count++;
				rgb_ch.ready <= 1'b0;
			end
		end else if (sink_wait > 0) begin
			sink_wait--;
			rgb_ch.ready <= 1'b0;
		end else begin
			rgb_ch.ready <= 1'b1;
			sink_wait = pick_gap(sink_mode);
		end
	end

	// Compare every output transfer with the oldest pending pixel
	always @(posedge clk) begin
		rgb_pixel_t want;
		if (arst_n && rgb_ch.valid && rgb_ch.ready) begin
			if (rgb_expected.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS) begin
					$display("unexpected pixel %0d: r=%0d g=%0d b=%0d", pixels_out,
						rgb_ch.red, rgb_ch.green, rgb_ch.blue);
				end
			end else begin
				want = rgb_expected.pop_front();
				if (rgb_ch.red !== want.red || rgb_ch.green !== want.green
					|| rgb_ch.blue !== want.blue) begin
					error_count++;
					if (error_count <= MAX_REPORTS) begin
						$display({"pixel %0d mismatch: expected r=%0d g=%0d b=%0d,",
							" got r=%0d g=%0d b=%0d"},
							pixels_out, want.red, want.green, want.blue,
							rgb_ch.red, rgb_ch.green, rgb_ch.blue);
					end
				end
			end
			pixels_out++;
		end
	end

	// Watchdog: end the run when no transfer happens for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((hsv_ch.valid && hsv_ch.ready) || (rgb_ch.valid && rgb_ch.ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Stimulus
	initial begin : stimulus
		rgb_pixel_t want;
		hsv_row_t   row;
		logic [8:0] hue;
		logic [7:0] sat;
		logic [7:0] bri;
		error_count  = 0;
		pixels_out   = 0;
		stall_cycles = 0;
		src_mode     = IDLE_SOME;
		sink_mode    = IDLE_SOME;
		hold_req     = 1'b0;
		hold_done    = 1'b0;
		hold_count   = 0;
		sink_wait    = 0;
		hsv_ch.valid       = 1'b0;
		hsv_ch.hue_degrees = '0;
		hsv_ch.saturation  = '0;
		hsv_ch.brightness  = '0;
		rgb_ch.ready       = 1'b0;
		arst_n             = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// directed table
		for (int i = 0; i < NUM_DIRECTED; i++) begin
			row = DIRECTED_ROWS[i];
			if (row.typed) begin
				want = '{row.red, row.green, row.blue};
			end else begin
				want = hsv_pixel_to_rgb(row.hue, row.sat, row.bri);
			end
			send_pixel(row.hue, row.sat, row.bri, want, pick_gap(src_mode));
		end

		// random pixels in chunks, the idling pattern following the chunk index
		for (int c = 0; c < RAND_CHUNKS; c++) begin
			src_mode  = (c % 4 == 1 || c % 4 == 3) ? IDLE_SOME : IDLE_NONE;
			sink_mode = (c % 4 == 2 || c % 4 == 3) ? IDLE_SOME : IDLE_NONE;
			if (c == HOLD_CHUNK) begin
				// keep offering while the output side holds off
				src_mode = IDLE_NONE;
				hold_req = 1'b1;
			end
			for (int i = 0; i < CHUNK_ITEMS; i++) begin
				hue = pick_hue();
				sat = pick_fraction();
				bri = pick_fraction();
				send_pixel(hue, sat, bri, hsv_pixel_to_rgb(hue, sat, bri),
					pick_gap(src_mode));
			end
		end
		hsv_ch.valid <= 1'b0;
		sink_mode = IDLE_SOME;

		// drain, then allow for stray output
		while (rgb_expected.size() > 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
